// ===== hw/rtl/bm3_pkg.sv =====
// Shared types and constants for the 3x3 binary morphology block.
// Used by bm3_window and binary_morphology_3x3; no dependencies.
package bm3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 24;
  localparam int DIM_W  = 11;
  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = DIM_W;
  // position arithmetic width: holds any column, row, dimension and dimension + 1
  localparam int POS_W  = ((ADDR_W > DIM_W) ? ADDR_W : DIM_W) + 2;

  localparam logic [PIX_W-1:0] WHITE = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] BLACK = 24'h000000;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(710);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(600);

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } bm3_cfg_t;

  // per-item control that travels with the row-store read
  typedef struct packed {
    logic have;   // item completes a window centre
    logic last;   // centre is the last pixel of the frame
    logic top;    // centre on first row
    logic bot;    // centre on last row
    logic lft;    // centre in first column
    logic rgt;    // centre in last column
  } bm3_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [POS_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (POS_W'(v) > hi) begin
      r = DIM_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/binary_morphology_3x3.sv =====
// 3x3 erosion/dilation on a raster stream of 24-bit RGB pixels.
// Depends on bm3_pkg, bm3_ram and bm3_window.
//
// Accepts one pixel per clock while in_ready is high. Each pixel does one read
// and one write of a single row-store RAM (upper and middle rows side by side,
// one entry per column); the read returns in the cycle after the transfer and
// the write-back and window update follow in that cycle, with forwarding when
// consecutive pixels hit the same column. A result is written into the 3-entry
// output queue at the end of the read stage of the pixel that completes its
// window, which is image_width+1 pixels after its own, and is then offered on
// pixel_out. in_ready drops only while the queued results and the one in the
// read stage fill all three queue slots, so input stalls come from result-side
// stalls alone. Send image_width+1 pad items after a frame to flush it; pads
// between frames are absorbed. The row store needs no clearing pass after
// reset. Writing mode, width or height restarts the frame position.
module binary_morphology_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [bm3_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bm3_pkg::PIX_W-1:0]     pixel_in,
  input  logic                          pad,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bm3_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_end
);

  localparam int PW = bm3_pkg::POS_W;
  localparam int XW = 2 * bm3_pkg::PIX_W;

  // configuration
  logic                        mode;
  logic [bm3_pkg::DIM_W-1:0]   width;
  logic [bm3_pkg::DIM_W-1:0]   height;

  // frame position of the next item
  logic [bm3_pkg::ADDR_W-1:0]  col;
  logic [bm3_pkg::ROW_W-1:0]   row;
  logic [bm3_pkg::ADDR_W-1:0]  col_next;
  logic [bm3_pkg::ROW_W-1:0]   row_next;

  logic [PW-1:0] wx, hx, col0, row0, cr, cc, col_inc, row_inc;
  logic          wrap, ignore, take, cand;
  logic [bm3_pkg::PIX_W-1:0]   x0;
  bm3_pkg::bm3_ctl_t           ctl0;

  // read stage
  logic                        s1_valid;
  logic                        s1_fwd;
  bm3_pkg::bm3_ctl_t           s1_ctl;
  logic [bm3_pkg::PIX_W-1:0]   s1_x;
  logic [bm3_pkg::ADDR_W-1:0]  s1_addr;
  logic [XW-1:0]               fwd_data;
  logic [XW-1:0]               ram_rdata;
  logic [XW-1:0]               rd;
  logic [XW-1:0]               wr_data;
  logic [bm3_pkg::PIX_W-1:0]   result;

  // output queue
  logic [bm3_pkg::PIX_W:0]     q_mem [3];
  logic [1:0]                  q_wr, q_rd, q_count;
  logic                        push, pop;
  logic [2:0]                  in_flight;

  assign cfg_ready = 1'b1;

  // ---------------- position and window control ----------------
  always_comb begin
    wx   = PW'(width);
    hx   = PW'(height);
    wrap = (PW'(col) >= wx) || (PW'(row) > hx + PW'(1));
    col0 = wrap ? '0 : PW'(col);
    row0 = wrap ? '0 : PW'(row);

    ignore = pad && (row0 == '0) && (col0 == '0);
    take   = in_valid && in_ready && !ignore;
    x0     = (row0 < hx) ? pixel_in : bm3_pkg::BLACK;

    if (col0 != '0) begin
      cand = (row0 >= PW'(1));
      cr   = row0 - PW'(1);
      cc   = col0 - PW'(1);
    end else begin
      cand = (row0 >= PW'(2));
      cr   = row0 - PW'(2);
      cc   = wx - PW'(1);
    end

    ctl0.have = cand && (cr < hx);
    ctl0.top  = (cr == '0);
    ctl0.bot  = (cr + PW'(1) >= hx);
    ctl0.lft  = (cc == '0);
    ctl0.rgt  = (cc + PW'(1) >= wx);
    ctl0.last = ctl0.have && (cr == hx - PW'(1)) && (cc == wx - PW'(1));

    col_inc = col0 + PW'(1);
    row_inc = row0 + PW'(1);
    if (ctl0.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= wx) begin
      col_next = '0;
      row_next = (row_inc > hx + PW'(1)) ? '0 : bm3_pkg::ROW_W'(row_inc);
    end else begin
      col_next = bm3_pkg::ADDR_W'(col_inc);
      row_next = bm3_pkg::ROW_W'(row0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      width  <= bm3_pkg::WIDTH_RESET;
      height <= bm3_pkg::HEIGHT_RESET;
      col    <= '0;
      row    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bm3_pkg::CFG_MODE: begin
          mode <= cfg_data[0];
          col  <= '0;
          row  <= '0;
        end
        bm3_pkg::CFG_WIDTH: begin
          width <= bm3_pkg::clamp_dim(cfg_data, PW'(bm3_pkg::MAX_WIDTH));
          col   <= '0;
          row   <= '0;
        end
        bm3_pkg::CFG_HEIGHT: begin
          height <= bm3_pkg::clamp_dim(cfg_data, PW'(bm3_pkg::MAX_HEIGHT));
          col    <= '0;
          row    <= '0;
        end
        default: begin
          // no register at this index: drop the write
        end
      endcase
    end else if (take) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // ---------------- row store ----------------
  bm3_ram #(
    .WIDTH (XW),
    .DEPTH (bm3_pkg::MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (take),
    .raddr (bm3_pkg::ADDR_W'(col0)),
    .rdata (ram_rdata)
  );

  // the RAM returns old data when the same column was written on the read edge
  assign rd      = s1_fwd ? fwd_data : ram_rdata;
  assign wr_data = {rd[bm3_pkg::PIX_W-1:0], s1_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else begin
      s1_valid <= take;
      s1_fwd   <= take && s1_valid && (s1_addr == bm3_pkg::ADDR_W'(col0));
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctl  <= ctl0;
      s1_x    <= x0;
      s1_addr <= bm3_pkg::ADDR_W'(col0);
    end
    if (s1_valid) begin
      fwd_data <= wr_data;
    end
  end

  bm3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (s1_valid),
    .up     (rd[XW-1:bm3_pkg::PIX_W]),
    .mid    (rd[bm3_pkg::PIX_W-1:0]),
    .x      (s1_x),
    .mode   (mode),
    .ctl    (s1_ctl),
    .result (result)
  );

  // ---------------- output queue ----------------
  assign push      = s1_valid && s1_ctl.have;
  assign pop       = out_valid && out_ready;
  assign out_valid = (q_count != 2'd0);
  assign pixel_out = q_mem[q_rd][bm3_pkg::PIX_W-1:0];
  assign frame_end = q_mem[q_rd][bm3_pkg::PIX_W];

  // every result already queued or still in the read stage holds a slot
  assign in_flight = {1'b0, q_count} + {2'b00, s1_valid && s1_ctl.have};
  assign in_ready  = (in_flight <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        q_wr <= (q_wr == 2'd2) ? 2'd0 : q_wr + 2'd1;
      end
      if (pop) begin
        q_rd <= (q_rd == 2'd2) ? 2'd0 : q_rd + 2'd1;
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr] <= {s1_ctl.last, result};
    end
  end

  // ---------------- checks ----------------
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != 2'd3) || pop)
    else $error("result pushed into a full output queue");

  a_fwd_taken: assert property (@(posedge clk) disable iff (rst)
    (take && s1_valid && (s1_addr == bm3_pkg::ADDR_W'(col0))) |=> s1_fwd)
    else $error("same-column read after write not forwarded");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid && $past(s1_valid))
    else $error("forwarding without a write on the read edge");

endmodule

// ===== hw/rtl/bm3_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bm3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bm3_window.sv =====
// 3x3 window registers and the masked white/black match for the centre pixel.
// Depends on bm3_pkg.
module bm3_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [bm3_pkg::PIX_W-1:0]    up,
  input  logic [bm3_pkg::PIX_W-1:0]    mid,
  input  logic [bm3_pkg::PIX_W-1:0]    x,
  input  logic                         mode,
  input  bm3_pkg::bm3_ctl_t            ctl,
  output logic [bm3_pkg::PIX_W-1:0]    result
);

  logic [bm3_pkg::PIX_W-1:0] win      [9];
  logic [bm3_pkg::PIX_W-1:0] win_next [9];
  logic [bm3_pkg::PIX_W-1:0] target;
  logic                      hit;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3 + 1];
      win_next[r*3 + 1] = win[r*3 + 2];
    end
    win_next[2] = up;
    win_next[5] = mid;
    win_next[8] = x;
  end

  // compare against the window as it stands after this shift
  always_comb begin
    target = mode ? bm3_pkg::BLACK : bm3_pkg::WHITE;
    hit    = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && ctl.top) || (r == 2 && ctl.bot) ||
              (c == 0 && ctl.lft) || (c == 2 && ctl.rgt)) &&
            win_next[r*3 + c] == target) begin
          hit = 1'b1;
        end
      end
    end
    result = hit ? target : win_next[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule
